/* rtl/core/sptq_pkg.sv */
// ----------------------------------------------------------------------------
// sptq_pkg
// shared types and codes for the stable priority task queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sptq_pkg;

    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned ID_W     = 16;
    localparam int unsigned FILL_W   = 5;
    localparam int unsigned STATUS_W = 2;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 3;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_OUT
    } t_state;

endpackage

/* rtl/core/stable_priority_task_queue.sv */
// ----------------------------------------------------------------------------
// stable_priority_task_queue
// bounded task queue served by priority, oldest first among equal priorities
// submit or failed take: goes straight from the transaction to the result
// take: scan of all N waiting tasks, then compaction of those after the winner unless the winner is newest
// the single store read port does the scan, then the compaction, one entry a cycle
// one item at a time; the next transaction is taken once the result is queued
// reset clears the count, the sequencer and the output stage; store is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_priority_task_queue
    import sptq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH  = 16,
    parameter int unsigned TASK_ID_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // priority_req [7:0], task_id [23:8]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // op [0]
    input  logic                 i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // granted_task [15:0], granted_priority [23:16], fill_level [28:24], zero [31:29]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // granted_valid [0], status [2:1]
    output logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int unsigned AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW    = (TASK_ID_BITS < ID_W) ? TASK_ID_BITS : ID_W;
    localparam int unsigned EW    = PRIO_W + SW;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    logic [EW-1:0]     r_rd_data;
    logic [AW-1:0]     r_best_idx, n_best_idx;
    logic [PRIO_W-1:0] r_best_prio, n_best_prio;
    logic [SW-1:0]     r_best_task, n_best_task;
    logic              r_res_grant, n_res_grant;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic              r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0] r_m_data, n_m_data;
    logic [M_TUSER_W-1:0] r_m_user, n_m_user;

    logic [EW-1:0] r_mem [QUEUE_DEPTH];

    logic              s_acc;
    logic              out_free;
    logic              rd_en;
    logic              rd_last;
    logic [CNT_W-1:0]  cnt_last;
    logic              is_full;
    logic              is_empty;
    logic [PRIO_W-1:0] rd_prio;
    logic [SW-1:0]     rd_task;
    logic              better;
    logic [AW-1:0]     scan_best_idx;
    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;
    logic [PRIO_W-1:0] in_prio;
    logic [SW-1:0]     in_task;
    logic [ID_W-1:0]   in_task_full;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    assign s_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free     = !r_m_valid || i_m_axis_tready;
    assign cnt_last     = r_count - 1'b1;
    assign is_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty     = (r_count == '0);
    assign rd_en        = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_idx < r_count);
    assign rd_last      = r_rd_vld && (CNT_W'(r_rd_idx) == cnt_last);
    assign rd_prio      = r_rd_data[EW-1:SW];
    assign rd_task      = r_rd_data[SW-1:0];
    assign better       = (r_rd_idx == '0) || (rd_prio > r_best_prio);
    assign scan_best_idx = better ? r_rd_idx : r_best_idx;
    assign in_prio      = i_s_axis_tdata[7:0];
    assign in_task_full = i_s_axis_tdata[23:8];
    assign in_task      = in_task_full[SW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_axis_tuser == OP_TAKE && !is_empty) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (rd_last) begin
                    n_state = (CNT_W'(scan_best_idx) == cnt_last) ? S_OUT : S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (rd_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_best_idx   = r_best_idx;
        n_best_prio  = r_best_prio;
        n_best_task  = r_best_task;
        n_res_grant  = r_res_grant;
        n_res_status = r_res_status;
        n_m_valid    = r_m_valid;
        n_m_data     = r_m_data;
        n_m_user     = r_m_user;
        mem_we       = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;

        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_res_grant  = 1'b0;
                    n_res_status = ST_OK;
                    if (i_s_axis_tuser == OP_SUBMIT) begin
                        if (is_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            wr_addr = r_count[AW-1:0];
                            wr_data = {in_prio, in_task};
                            n_count = r_count + 1'b1;
                        end
                    end else if (is_empty) begin
                        n_res_status = ST_EMPTY;
                    end else begin
                        n_res_grant = 1'b1;
                        n_idx       = '0;
                    end
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rd_vld && better) begin
                    n_best_idx  = r_rd_idx;
                    n_best_prio = rd_prio;
                    n_best_task = rd_task;
                end
                if (rd_last) begin
                    if (CNT_W'(scan_best_idx) == cnt_last) begin
                        n_count = cnt_last;
                    end else begin
                        n_idx = CNT_W'(scan_best_idx) + 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                if (rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rd_vld) begin
                    mem_we  = 1'b1;
                    wr_addr = r_rd_idx - 1'b1;
                    wr_data = r_rd_data;
                end
                if (rd_last) begin
                    n_count = cnt_last;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {3'b000,
                                 FILL_W'(r_count),
                                 r_res_grant ? r_best_prio : {PRIO_W{1'b0}},
                                 r_res_grant ? ID_W'(r_best_task) : {ID_W{1'b0}}};
                    n_m_user  = {r_res_status, r_res_grant};
                end
            end
        endcase
    end

    // task store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_rd_vld  <= rd_en;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= r_idx[AW-1:0];
        r_best_idx   <= n_best_idx;
        r_best_prio  <= n_best_prio;
        r_best_task  <= n_best_task;
        r_res_grant  <= n_res_grant;
        r_res_status <= n_res_status;
        r_m_data     <= n_m_data;
        r_m_user     <= n_m_user;
    end

endmodule

/* rtl/core/sptq_checker.sv */
// ----------------------------------------------------------------------------
// sptq_checker
// port level checks for the stable priority task queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sptq_checker
    import sptq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // one transaction in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("accepted a transaction while busy");

    // a grant always carries ok status
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tuser[2:1] == ST_OK)
        else $error("grant with error status");

    // empty take reports an empty queue
    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2:1] == ST_EMPTY |->
            o_m_axis_tdata[28:24] == '0 && !o_m_axis_tuser[0])
        else $error("empty status with waiting tasks");

    // rejected submit reports a full queue
    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2:1] == ST_FULL |->
            o_m_axis_tdata[28:24] == FULL_FILL)
        else $error("full status without a full queue");

endmodule

bind stable_priority_task_queue sptq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_sptq_checker (.*);
